// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ZZSO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zigzag scan check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ZZSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zigzag scan check failed");

`endif

// ===== rtl/zzso_pkg.sv =====
// Shared widths and constants of the zigzag scan order generator.
package zzso_pkg;

    localparam int SIZE_W     = 5;
    localparam int ROW_W      = 4;
    localparam int ORDER_W    = 9;
    localparam int SIZE_RESET = 8;

    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [ROW_W-1:0]   coord_t;
    typedef logic [ORDER_W-1:0] order_t;

endpackage

// ===== rtl/zigzag_scan_order_generator.sv =====
// Zigzag scan order generator: one matrix position per accepted word.
// The output word of an accepted input word is registered and appears in the cycle after it is accepted.
// Throughput is one word per cycle while out_ready is high; the output register frees in the cycle it is taken.
// Reset clears the scan and sets the matrix size to 8; a size write also clears the scan.
// The first word after reset, after a size write or after the last cell gives cell (0,0).
module zigzag_scan_order_generator #(
    parameter int MAX_SIZE = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  zzso_pkg::size_t         cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output zzso_pkg::coord_t        row,
    output zzso_pkg::coord_t        column,
    output zzso_pkg::order_t        order_number,
    output logic                    last
);
    import zzso_pkg::*;

    localparam int CW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int TW = 2 * NW;

    logic [SIZE_W-1:0] size_reg;
    logic [CW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic              up_right_reg, up_right_next;
    logic [TW-1:0]     count_reg, count_next;

    logic              out_valid_reg;
    logic [CW-1:0]     row_reg;
    logic [CW-1:0]     col_reg;
    logic [TW-1:0]     order_reg;
    logic              last_reg;

    logic [NW-1:0]     size_eff;
    logic [NW-1:0]     edge_pos;
    logic [TW-1:0]     total;
    logic              accept;
    logic              wrap;
    logic              at_col_edge;
    logic              at_row_edge;
    logic [CW+ROW_W-1:0]   row_ext;
    logic [CW+ROW_W-1:0]   col_ext;
    logic [TW+ORDER_W-1:0] order_ext;

    always_comb
    begin
        if (size_reg == '0)
        begin
            size_eff = NW'(1);
        end
        else if (int'(size_reg) > MAX_SIZE)
        begin
            size_eff = NW'(MAX_SIZE);
        end
        else
        begin
            size_eff = NW'(size_reg);
        end
    end

    assign edge_pos    = size_eff - NW'(1);
    assign total       = TW'(size_eff) * TW'(size_eff);
    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign wrap        = restart || (count_reg == '0) || (count_reg >= total);
    assign at_col_edge = NW'(cur_col_reg) == edge_pos;
    assign at_row_edge = NW'(cur_row_reg) == edge_pos;

    always_comb
    begin
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        up_right_next = up_right_reg;
        count_next    = count_reg + TW'(1);
        if (wrap)
        begin
            cur_row_next  = '0;
            cur_col_next  = '0;
            up_right_next = 1'b0;
            count_next    = TW'(1);
        end
        else if (up_right_reg)
        begin
            if (at_col_edge)
            begin
                cur_row_next  = cur_row_reg + CW'(1);
                up_right_next = 1'b0;
            end
            else if (cur_row_reg == '0)
            begin
                cur_col_next  = cur_col_reg + CW'(1);
                up_right_next = 1'b0;
            end
            else
            begin
                cur_row_next = cur_row_reg - CW'(1);
                cur_col_next = cur_col_reg + CW'(1);
            end
        end
        else
        begin
            if (at_row_edge)
            begin
                cur_col_next  = cur_col_reg + CW'(1);
                up_right_next = 1'b1;
            end
            else if (cur_col_reg == '0)
            begin
                cur_row_next  = cur_row_reg + CW'(1);
                up_right_next = 1'b1;
            end
            else
            begin
                cur_row_next = cur_row_reg + CW'(1);
                cur_col_next = cur_col_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_W'(SIZE_RESET);
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            up_right_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg     <= cfg_wdata;
                cur_row_reg  <= '0;
                cur_col_reg  <= '0;
                up_right_reg <= 1'b0;
                count_reg    <= '0;
            end
            else if (accept)
            begin
                cur_row_reg  <= cur_row_next;
                cur_col_reg  <= cur_col_next;
                up_right_reg <= up_right_next;
                count_reg    <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg   <= cur_row_next;
            col_reg   <= cur_col_next;
            order_reg <= count_next;
            last_reg  <= count_next == total;
        end
    end

    assign row_ext   = {{ROW_W{1'b0}}, row_reg};
    assign col_ext   = {{ROW_W{1'b0}}, col_reg};
    assign order_ext = {{ORDER_W{1'b0}}, order_reg};

    assign out_valid    = out_valid_reg;
    assign row          = row_ext[ROW_W-1:0];
    assign column       = col_ext[ROW_W-1:0];
    assign order_number = order_ext[ORDER_W-1:0];
    assign last         = last_reg;

endmodule

// ===== rtl/zzso_checker.sv =====
// Port-level checker for the zigzag scan order generator and its bind.
`include "assert_macros.svh"

module zzso_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    restart,
    input logic                    out_valid,
    input logic                    out_ready,
    input zzso_pkg::coord_t        row,
    input zzso_pkg::coord_t        column,
    input zzso_pkg::order_t        order_number,
    input logic                    last
);
    import zzso_pkg::*;

    // An accepted word always shows up at the output in the next cycle.
    `ZZSO_ASSERT_NEXT(a_accept_gives_word, clk, rst_n, in_valid && in_ready, out_valid)

    // A restart word yields the first cell of the scan.
    `ZZSO_ASSERT_NEXT(a_restart_origin, clk, rst_n, in_valid && in_ready && restart,
        row == '0 && column == '0 && order_number == order_t'(1))

    // Every output word carries a nonzero order number.
    `ZZSO_ASSERT_NOW(a_order_nonzero, clk, rst_n, out_valid, order_number != '0)

    // The first cell of any scan is the origin.
    `ZZSO_ASSERT_NOW(a_first_is_origin, clk, rst_n, out_valid && order_number == order_t'(1),
        row == '0 && column == '0)

    // A stalled output word holds.
    `ZZSO_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(row) && $stable(column) && $stable(order_number) && $stable(last))

endmodule

bind zigzag_scan_order_generator zzso_checker u_zzso_checker (.*);
